@@ design/rsmp_pkg.sv @@
package rsmp_pkg;

  // Output rate, the rates that select the fixed window forms, and the clamp limits
  localparam int OUT_RATE  = 16000;
  localparam int RATE_44K  = 44100;
  localparam int RATE_48K  = 48000;
  localparam int MAX_RATE  = 192000;
  localparam int MAX_CH    = 8;
  localparam int MAX_BPS   = 4;

  // Reciprocal of the output rate for the quotient estimate
  localparam int     RECIP_SHIFT = 32;
  localparam longint RECIP       = (64'd1 << RECIP_SHIFT) / OUT_RATE;

  localparam int QUEUE_DEPTH   = 4;
  localparam int SETTLE_CYCLES = 5;
  localparam int DIV_STEPS     = 40;

  typedef enum logic [1:0] {
    CFG_BPS   = 2'd0,
    CFG_CH    = 2'd1,
    CFG_RATE  = 2'd2,
    CFG_CHUNK = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_RAW     = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_DIV,
    ST_EMIT,
    ST_FIN,
    ST_CONS,
    ST_RPT_PEND,
    ST_RPT
  } bk_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] sv;
    logic               eob;
    logic [22:0]        rel;
  } item_t;

  typedef struct packed {
    logic [2:0]  s;
    logic [6:0]  q;
    logic [13:0] rem;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [6:0]  fdiv;
    logic [21:0] thr;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] sample_value;
    logic [31:0]        consumed_bytes;
    logic               chunk_ready;
    logic               overflow_seen;
    logic [22:0]        fill_level;
    logic               last_result;
  } result_t;

endpackage

@@ design/rsmp_if.sv @@
interface rsmp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] raw_sample;
  logic        end_of_buffer;
  logic [22:0] release_count;

  modport source (output valid, command, raw_sample, end_of_buffer, release_count,
                  input ready);
  modport sink   (input valid, command, raw_sample, end_of_buffer, release_count,
                  output ready);
endinterface

interface rsmp_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] sample_value;
  logic [31:0]        consumed_bytes;
  logic               chunk_ready;
  logic               overflow_seen;
  logic [22:0]        fill_level;
  logic               last_result;

  modport source (output valid, result_kind, sample_value, consumed_bytes, chunk_ready,
                  overflow_seen, fill_level, last_result, input ready);
  modport sink   (input valid, result_kind, sample_value, consumed_bytes, chunk_ready,
                  overflow_seen, fill_level, last_result, output ready);
endinterface

interface rsmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/rsmp_cfg.sv @@
module rsmp_cfg import rsmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  input  logic [1:0]  wr_index_i,
  input  logic [31:0] wr_data_i,
  output logic [2:0]  bps_o,
  output cfg_t        cfg_o,
  output logic        settled_o
);

  logic [2:0]  bps_q;
  logic [3:0]  ch_q;
  logic [17:0] rate_q;
  logic [7:0]  chunk_q;

  logic [2:0]  s_c;
  logic [3:0]  c_c;
  logic [17:0] r_c;

  // stage registers of the derivation pipeline
  logic [20:0] m1_q, m2_q;
  logic [2:0]  s1_q, s2_q, s3_q;
  logic [3:0]  c1_q, c2_q, c3_q;
  logic [17:0] r1_q, r2_q, r3_q;
  logic [21:0] thr1_q, thr2_q, thr3_q;
  logic [6:0]  qe2_q, qe3_q;
  logic [14:0] rem3_q;
  logic [39:0] prod2_w;
  logic [21:0] diff3_w;
  cfg_t        cfg_d, cfg_q;
  logic [2:0]  cnt_q;

  logic [6:0]  q4_w;
  logic [13:0] rem4_w;
  logic        set_w;

  // Write the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q   <= 3'd2;
      ch_q    <= 4'd1;
      rate_q  <= 18'(OUT_RATE);
      chunk_q <= 8'd30;
      cnt_q   <= 3'(SETTLE_CYCLES);
    end else begin
      if (wr_valid_i) begin
        cnt_q <= 3'(SETTLE_CYCLES);
        case (cfg_idx_e'(wr_index_i))
          CFG_BPS:   bps_q   <= wr_data_i[2:0];
          CFG_CH:    ch_q    <= wr_data_i[3:0];
          CFG_RATE:  rate_q  <= wr_data_i[17:0];
          CFG_CHUNK: chunk_q <= wr_data_i[7:0];
          default:   bps_q   <= bps_q;
        endcase
      end else if (cnt_q != 3'd0) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  // Clamp out-of-range settings
  always_comb begin
    s_c = (bps_q == 3'd0) ? 3'd1 : ((bps_q > 3'(MAX_BPS)) ? 3'(MAX_BPS) : bps_q);
    c_c = (ch_q == 4'd0) ? 4'd1 : ((ch_q > 4'(MAX_CH)) ? 4'(MAX_CH) : ch_q);
    r_c = (rate_q == 18'd0) ? 18'd1 :
          ((rate_q > 18'(MAX_RATE)) ? 18'(MAX_RATE) : rate_q);
  end

  assign prod2_w = 40'(m1_q) * 40'(RECIP);
  assign diff3_w = 22'(m2_q) - 22'(qe2_q) * 22'(OUT_RATE);

  // Correct the quotient estimate and pick the window form
  always_comb begin
    if (rem3_q >= 15'(OUT_RATE)) begin
      q4_w   = qe3_q + 7'd1;
      rem4_w = 14'(rem3_q - 15'(OUT_RATE));
    end else begin
      q4_w   = qe3_q;
      rem4_w = rem3_q[13:0];
    end
    set_w = ((c3_q == 4'd1) || (c3_q == 4'd2)) &&
            ((r3_q == 18'(OUT_RATE)) || (r3_q == 18'(RATE_44K)) ||
             (r3_q == 18'(RATE_48K))) &&
            !((s3_q == 3'd1) && (c3_q == 4'd2));
    cfg_d     = '0;
    cfg_d.s   = s3_q;
    cfg_d.q   = q4_w;
    cfg_d.rem = rem4_w;
    cfg_d.thr = thr3_q;
    cfg_d.lo  = 7'd0;
    cfg_d.hi  = (q4_w == 7'd0) ? 7'd0 : q4_w - 7'd1;
    if (set_w && (rem4_w == 14'd0)) begin
      case (q4_w)
        7'd1: begin cfg_d.lo = 7'd0; cfg_d.hi = 7'd0; end
        7'd2: begin cfg_d.lo = 7'd0; cfg_d.hi = 7'd1; end
        7'd3: begin cfg_d.lo = 7'd1; cfg_d.hi = 7'd1; end
        7'd6: begin cfg_d.lo = 7'd2; cfg_d.hi = 7'd3; end
        default: cfg_d.lo = 7'd0;
      endcase
    end else if (set_w && (r3_q == 18'(RATE_44K))) begin
      if (c3_q == 4'd1) begin
        cfg_d.lo = 7'd1;
        cfg_d.hi = 7'd1;
      end else begin
        cfg_d.lo = 7'd2;
        cfg_d.hi = 7'd3;
      end
    end
    cfg_d.fdiv = cfg_d.hi - cfg_d.lo + 7'd1;
  end

  // Advance the derivation pipeline
  always_ff @(posedge clk_i) begin
    m1_q   <= 21'(22'(c_c) * 22'(r_c));
    s1_q   <= s_c;
    c1_q   <= c_c;
    r1_q   <= r_c;
    thr1_q <= 22'(22'(chunk_q) * 22'(OUT_RATE));
    qe2_q  <= prod2_w[38:32];
    m2_q   <= m1_q;
    s2_q   <= s1_q;
    c2_q   <= c1_q;
    r2_q   <= r1_q;
    thr2_q <= thr1_q;
    rem3_q <= diff3_w[14:0];
    qe3_q  <= qe2_q;
    s3_q   <= s2_q;
    c3_q   <= c2_q;
    r3_q   <= r2_q;
    thr3_q <= thr2_q;
    cfg_q  <= cfg_d;
  end

  assign bps_o     = s_c;
  assign cfg_o     = cfg_q;
  assign settled_o = (cnt_q == 3'd0);

endmodule

@@ design/rsmp_front.sv @@
module rsmp_front import rsmp_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] raw_sample_i,
  input  logic        end_of_buffer_i,
  input  logic [22:0] release_count_i,
  input  logic [2:0]  bps_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  cmd_e cmd_w;

  assign cmd_w      = cmd_e'(command_i);
  assign in_ready_o = !full_i;
  // drop ignored commands here, queue the rest
  assign push_o     = in_valid_i && !full_i && (cmd_w != CMD_NOP);

  // Left-justify the raw sample
  always_comb begin
    item_o     = '0;
    item_o.cmd = cmd_w;
    item_o.eob = end_of_buffer_i;
    item_o.rel = release_count_i;
    case (bps_i)
      3'd1:    item_o.sv = $signed({raw_sample_i[7:0], 24'd0});
      3'd2:    item_o.sv = $signed({raw_sample_i[15:0], 16'd0});
      3'd3:    item_o.sv = $signed({raw_sample_i[23:0], 8'd0});
      default: item_o.sv = $signed(raw_sample_i);
    endcase
  end

endmodule

@@ design/rsmp_queue.sv @@
module rsmp_queue import rsmp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign item_o  = mem_q[rd_q];

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ design/rsmp_div.sv @@
module rsmp_div import rsmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [39:0] dividend_i,
  input  logic [6:0]         divisor_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [39:0] mag_q, mag_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [7:0]  trial_w;
  logic        ge_w;
  logic [39:0] quot_w;

  assign trial_w = {rem_q, mag_q[39]};
  assign ge_w    = trial_w >= {1'b0, dvs_q};

  // One quotient bit a cycle, restoring form
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      neg_d = dividend_i[39];
      mag_d = dividend_i[39] ? 40'(-dividend_i) : 40'(dividend_i);
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge_w ? 7'(trial_w - {1'b0, dvs_q}) : trial_w[6:0];
      mag_d = {mag_q[38:0], ge_w};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // Restore the sign: truncation toward zero
  assign quot_w = neg_q ? -mag_q : mag_q;
  assign quot_o = $signed(quot_w[31:0]);
  assign done_o = done_q;

endmodule

@@ design/rsmp_back.sv @@
module rsmp_back import rsmp_pkg::*; #(
  parameter int STORE_CAPACITY = 4194304
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    settled_i,
  input  item_t   item_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int CW   = $clog2(STORE_CAPACITY + 1);
  localparam int CMPW = (CW > 23) ? CW : 23;

  bk_state_e          state_q, state_d;
  logic [31:0]        raw_pos_q, raw_pos_d;
  logic [31:0]        ws_q, ws_d;
  logic [13:0]        pr_q, pr_d;
  logic signed [39:0] sum_q, sum_d;
  logic [CW-1:0]      stored_q, stored_d;
  logic               drop_q, drop_d;
  logic [31:0]        bst_q, bst_d;
  logic               pend_v_q, pend_v_d;
  logic               ov_q, ov_d;
  item_t              cur_q, cur_d;
  logic [31:0]        p_q, p_d;
  logic [1:0]         n_q, n_d;
  result_t            pend_q, pend_d;
  logic signed [31:0] val_q, val_d;
  logic [31:0]        cq_q, cq_d;
  logic [13:0]        cr_q, cr_d;
  logic [4:0]         cnt_q, cnt_d;
  result_t            out_q, out_d;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;

  logic               ofree_w;
  logic [31:0]        dist_w;
  logic               in_win_w;
  logic signed [39:0] sum_new_w;
  logic signed [39:0] rnd_w;
  logic signed [39:0] half_w;
  logic [14:0]        nr_raw_w;
  logic               carry_w;
  logic [13:0]        nr_w;
  logic [31:0]        ns_w;
  logic [31:0]        edge_w;
  logic               complete_w;
  logic               room_w;
  logic [CMPW-1:0]    st_ext_w;
  logic [22:0]        fill_w;
  logic               chunk_w;
  logic               bit_w;
  logic [14:0]        t1_w, t2_w;
  logic               c1_w, c2_w;
  logic [13:0]        t1b_w;
  logic [31:0]        cons_w;

  rsmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new_w),
    .divisor_i  (cfg_i.fdiv),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Window membership, phase step and output completion
  always_comb begin
    dist_w     = p_q - ws_q;
    in_win_w   = (dist_w >= 32'(cfg_i.lo)) && (dist_w <= 32'(cfg_i.hi));
    sum_new_w  = sum_q + (in_win_w ? 40'(cur_q.sv) : 40'sd0);
    rnd_w      = sum_new_w + $signed({39'd0, sum_new_w[39]});
    half_w     = rnd_w >>> 1;
    nr_raw_w   = 15'(pr_q) + 15'(cfg_i.rem);
    carry_w    = nr_raw_w >= 15'(OUT_RATE);
    nr_w       = carry_w ? 14'(nr_raw_w - 15'(OUT_RATE)) : nr_raw_w[13:0];
    ns_w       = ws_q + 32'(cfg_i.q) + 32'(carry_w);
    edge_w     = ns_w + 32'(nr_w != 14'd0);
    complete_w = (edge_w == raw_pos_q);
    room_w     = (stored_q < CW'(STORE_CAPACITY)) &&
                 (n_q < (cur_q.eob ? 2'd1 : 2'd2));
    st_ext_w   = CMPW'(stored_q);
    fill_w     = st_ext_w[22:0];
    chunk_w    = 32'(stored_q) >= 32'(cfg_i.thr);
  end

  // Byte count: one bit of the stored count a cycle, kept modulo the rate
  always_comb begin
    bit_w = bst_q[5'd31 - cnt_q];
    t1_w  = {cr_q, 1'b0};
    c1_w  = t1_w >= 15'(OUT_RATE);
    t1b_w = c1_w ? 14'(t1_w - 15'(OUT_RATE)) : t1_w[13:0];
    t2_w  = 15'(t1b_w) + (bit_w ? 15'(cfg_i.rem) : 15'd0);
    c2_w  = t2_w >= 15'(OUT_RATE);
    case (cfg_i.s)
      3'd1:    cons_w = cq_q;
      3'd2:    cons_w = {cq_q[30:0], 1'b0};
      3'd3:    cons_w = cq_q + {cq_q[30:0], 1'b0};
      default: cons_w = {cq_q[29:0], 2'b00};
    endcase
  end

  assign ofree_w = !ov_q || out_ready_i;

  // Sequence the work on one item
  always_comb begin
    state_d   = state_q;
    raw_pos_d = raw_pos_q;
    ws_d      = ws_q;
    pr_d      = pr_q;
    sum_d     = sum_q;
    stored_d  = stored_q;
    drop_d    = drop_q;
    bst_d     = bst_q;
    pend_v_d  = pend_v_q;
    cur_d     = cur_q;
    p_d       = p_q;
    n_d       = n_q;
    pend_d    = pend_q;
    val_d     = val_q;
    cq_d      = cq_q;
    cr_d      = cr_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    ov_d      = ov_q && !out_ready_i;
    pop_o     = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i && settled_i) begin
          pop_o = 1'b1;
          case (item_i.cmd)
            CMD_CLEAR: stored_d = '0;
            CMD_RELEASE: begin
              if (CMPW'(item_i.rel) >= st_ext_w) stored_d = '0;
              else stored_d = CW'(st_ext_w - CMPW'(item_i.rel));
            end
            CMD_RAW: begin
              cur_d     = item_i;
              p_d       = raw_pos_q;
              raw_pos_d = raw_pos_q + 32'd1;
              n_d       = 2'd0;
              state_d   = ST_ITER;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_ITER: begin
        if (!complete_w) begin
          sum_d = sum_new_w;
          if (cur_q.eob) begin
            cq_d    = '0;
            cr_d    = '0;
            cnt_d   = '0;
            state_d = ST_CONS;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          ws_d  = ns_w;
          pr_d  = nr_w;
          sum_d = '0;
          if (room_w) begin
            stored_d = stored_q + 1'b1;
            bst_d    = bst_q + 32'd1;
            n_d      = n_q + 2'd1;
            if (cfg_i.fdiv == 7'd1) begin
              val_d   = sum_new_w[31:0];
              state_d = ST_EMIT;
            end else if (cfg_i.fdiv == 7'd2) begin
              val_d   = half_w[31:0];
              state_d = ST_EMIT;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else begin
            drop_d = 1'b1;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          val_d   = div_quot;
          state_d = ST_EMIT;
        end
      end

      // Hold one sample back until it is known whether it ends the step
      ST_EMIT: begin
        if (!pend_v_q || ofree_w) begin
          if (pend_v_q) begin
            out_d             = pend_q;
            out_d.last_result = 1'b0;
            ov_d              = 1'b1;
          end
          pend_d                = '0;
          pend_d.kind           = KIND_SAMPLE;
          pend_d.sample_value   = val_q;
          pend_d.chunk_ready    = chunk_w;
          pend_d.overflow_seen  = drop_q;
          pend_d.fill_level     = fill_w;
          pend_v_d              = 1'b1;
          state_d               = ST_ITER;
        end
      end

      ST_FIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (ofree_w) begin
          out_d             = pend_q;
          out_d.last_result = 1'b1;
          ov_d              = 1'b1;
          pend_v_d          = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      ST_CONS: begin
        cr_d  = c2_w ? 14'(t2_w - 15'(OUT_RATE)) : t2_w[13:0];
        cq_d  = {cq_q[30:0], 1'b0} + (bit_w ? 32'(cfg_i.q) : 32'd0) +
                32'(c1_w) + 32'(c2_w);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = ST_RPT_PEND;
      end

      ST_RPT_PEND: begin
        if (!pend_v_q) begin
          state_d = ST_RPT;
        end else if (ofree_w) begin
          out_d             = pend_q;
          out_d.last_result = 1'b0;
          ov_d              = 1'b1;
          pend_v_d          = 1'b0;
          state_d           = ST_RPT;
        end
      end

      // Report the buffer, then restart the phase
      ST_RPT: begin
        if (ofree_w) begin
          out_d                = '0;
          out_d.kind           = KIND_REPORT;
          out_d.consumed_bytes = cons_w;
          out_d.chunk_ready    = chunk_w;
          out_d.overflow_seen  = drop_q;
          out_d.fill_level     = fill_w;
          out_d.last_result    = 1'b1;
          ov_d                 = 1'b1;
          raw_pos_d            = '0;
          ws_d                 = '0;
          pr_d                 = '0;
          sum_d                = '0;
          bst_d                = '0;
          drop_d               = 1'b0;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      raw_pos_q <= '0;
      ws_q      <= '0;
      pr_q      <= '0;
      sum_q     <= '0;
      stored_q  <= '0;
      drop_q    <= 1'b0;
      bst_q     <= '0;
      pend_v_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      raw_pos_q <= raw_pos_d;
      ws_q      <= ws_d;
      pr_q      <= pr_d;
      sum_q     <= sum_d;
      stored_q  <= stored_d;
      drop_q    <= drop_d;
      bst_q     <= bst_d;
      pend_v_q  <= pend_v_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    p_q    <= p_d;
    n_q    <= n_d;
    pend_q <= pend_d;
    val_q  <= val_d;
    cq_q   <= cq_d;
    cr_q   <= cr_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

@@ design/pcm_to_16k_mono_resampler.sv @@
// Path: a raw item waits in the queue until the settled, idle work stage pops it; each
//   result leaves through the output register. The window mean uses the serial divider
//   unless the window holds one or two samples; an end-of-buffer report works out its
//   byte count serially. Commands 1 and 2 are done as they are popped. The queue takes
//   new items while the work stage is busy, until full; the work stage, its divider and
//   output back-pressure set the rate. Reset: settings go to 2 bytes, 1 channel, 16000 Hz,
//   30 s; all counts clear; no item is worked on until settled after reset or a write.
module pcm_to_16k_mono_resampler import rsmp_pkg::*; #(
  parameter int STORE_CAPACITY = 4194304
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rsmp_cfg_if.sink cfg_i,
  rsmp_in_if.sink  in_i,
  rsmp_out_if.source out_o
);

  logic    [2:0] bps;
  cfg_t          cfg;
  logic          settled;
  logic          push;
  item_t         push_item;
  item_t         head_item;
  logic          pop;
  logic          empty;
  logic          full;
  result_t       res;
  logic          res_valid;

  assign cfg_i.ready = 1'b1;

  rsmp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .bps_o      (bps),
    .cfg_o      (cfg),
    .settled_o  (settled)
  );

  rsmp_front u_front (
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .command_i       (in_i.command),
    .raw_sample_i    (in_i.raw_sample),
    .end_of_buffer_i (in_i.end_of_buffer),
    .release_count_i (in_i.release_count),
    .bps_i           (bps),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  rsmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty),
    .full_o  (full)
  );

  rsmp_back #(
    .STORE_CAPACITY (STORE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .settled_i   (settled),
    .item_i      (head_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (res_valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.valid          = res_valid;
  assign out_o.result_kind    = res.kind;
  assign out_o.sample_value   = res.sample_value;
  assign out_o.consumed_bytes = res.consumed_bytes;
  assign out_o.chunk_ready    = res.chunk_ready;
  assign out_o.overflow_seen  = res.overflow_seen;
  assign out_o.fill_level     = res.fill_level;
  assign out_o.last_result    = res.last_result;

endmodule

@@ design/rsmp_chk.sv @@
module rsmp_chk import rsmp_pkg::*; #(
  parameter int STORE_CAPACITY = 4194304
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        result_kind_i,
  input logic [31:0] sample_value_i,
  input logic [31:0] consumed_bytes_i,
  input logic [22:0] fill_level_i,
  input logic        last_result_i
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_value_i) &&
    $stable(last_result_i))
    else $error("output item changed while stalled");

  // a report closes the results of its item and carries no sample
  a_rpt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_REPORT) |->
    last_result_i && (sample_value_i == 32'd0))
    else $error("report is not the last result or carries a sample");

  // a sample carries no byte count
  a_smp_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_SAMPLE) |-> (consumed_bytes_i == 32'd0))
    else $error("sample carries a byte count");

  // the fill level never passes the store size
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(fill_level_i) <= 32'(STORE_CAPACITY)))
    else $error("fill level above store size");

endmodule

bind pcm_to_16k_mono_resampler rsmp_chk #(
  .STORE_CAPACITY (STORE_CAPACITY)
) u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_kind_i    (out_o.result_kind),
  .sample_value_i   (out_o.sample_value),
  .consumed_bytes_i (out_o.consumed_bytes),
  .fill_level_i     (out_o.fill_level),
  .last_result_i    (out_o.last_result)
);
